// ----- hdl/ryc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter package
// Shared sizes, BT.601 fixed-point coefficients, register indexes and the
// structs that pass between the converter's submodules.
// ----------------------------------------------------------------------------
package ryc_pkg;

   // Widest line the chroma line store supports, and the sizes it sets.
   localparam int MAX_LINE_WIDTH = 4096;
   localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
   localparam int SLOT_W         = COL_W - 1;
   localparam int STORE_DEPTH    = MAX_LINE_WIDTH / 2;
   localparam int CMP_W          = (COL_W + 1 > 13) ? COL_W + 1 : 13;

   // Fixed field and register sizes.
   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int CFG_W      = 13;
   localparam int PAIR_W     = 9;
   localparam int BLOCK_W    = 10;
   localparam int ENTRY_W    = 2 * PAIR_W;
   localparam int PROD_W     = 24;
   localparam int COEF_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_LINE_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = '1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PIXELS_PER_LINE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_LINES_PER_FRAME = 1'b1;

   localparam logic [CFG_W-1:0] PIXELS_PER_LINE_RESET = 13'd3840;
   localparam logic [CFG_W-1:0] LINES_PER_FRAME_RESET = 13'd2160;

   // BT.601 coefficients scaled by 2^16 and rounded.
   localparam logic [COEF_W-1:0] C_Y_R = 16'd16843;
   localparam logic [COEF_W-1:0] C_Y_G = 16'd33030;
   localparam logic [COEF_W-1:0] C_Y_B = 16'd6423;
   localparam logic [COEF_W-1:0] C_U_R = 16'd9699;
   localparam logic [COEF_W-1:0] C_U_G = 16'd19071;
   localparam logic [COEF_W-1:0] C_U_B = 16'd28770;
   localparam logic [COEF_W-1:0] C_V_R = 16'd28770;
   localparam logic [COEF_W-1:0] C_V_G = 16'd24117;
   localparam logic [COEF_W-1:0] C_V_B = 16'd4653;

   localparam logic [PROD_W-1:0] Y_OFFSET  = PROD_W'(16 << 16);
   localparam logic [PROD_W-1:0] UV_OFFSET = PROD_W'(128 << 16);

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [CFG_W-1:0] pixels_per_line;
      logic [CFG_W-1:0] lines_per_frame;
   } ryc_cfg_type;

   // One converted pixel with its position tags.
   typedef struct packed {
      logic [PIX_W-1:0]  luma;
      logic [PIX_W-1:0]  u;
      logic [PIX_W-1:0]  v;
      logic              odd_col;
      logic              odd_row;
      logic [SLOT_W-1:0] slot;
   } ryc_yuv_type;

   // Line store read request.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
   } ryc_rd_type;

endpackage

// ----- hdl/ryc_ifs.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter stream interfaces
// Valid/ready channels for the pixel input and the converted result output.
// ----------------------------------------------------------------------------
interface ryc_pixel_if import ryc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface ryc_result_if import ryc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] luma;
   logic             chroma_valid;
   logic [PIX_W-1:0] chroma_u;
   logic [PIX_W-1:0] chroma_v;

   modport source (output valid, output luma, output chroma_valid, output chroma_u,
                   output chroma_v, input ready);
   modport sink (input valid, input luma, input chroma_valid, input chroma_u,
                 input chroma_v, output ready);
endinterface

// ----- hdl/ryc_csr.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter registers
// APB-style register file holding the line width and the frame height.
// ----------------------------------------------------------------------------
module ryc_csr import ryc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output ryc_cfg_type           cfg
);

   logic [CFG_W-1:0]     ppl_ff, ppl_in;
   logic [CFG_W-1:0]     lpf_ff, lpf_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_xfer;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_xfer    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Write decode: a transfer updates the addressed register.
   always_comb begin
      ppl_in = ppl_ff;
      lpf_in = lpf_ff;
      if (wr_xfer) begin
         unique case (reg_idx)
            REG_PIXELS_PER_LINE: ppl_in = csr_pwdata[CFG_W-1:0];
            REG_LINES_PER_FRAME: lpf_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppl_ff <= PIXELS_PER_LINE_RESET;
         lpf_ff <= LINES_PER_FRAME_RESET;
      end else begin
         ppl_ff <= ppl_in;
         lpf_ff <= lpf_in;
      end
   end

   // Read decode.
   always_comb begin
      unique case (reg_idx)
         REG_PIXELS_PER_LINE: csr_prdata = CSR_DATA_W'(ppl_ff);
         REG_LINES_PER_FRAME: csr_prdata = CSR_DATA_W'(lpf_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.pixels_per_line = ppl_ff;
   assign cfg.lines_per_frame = lpf_ff;

endmodule

// ----- hdl/ryc_color.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter color matrix
// Tracks the raster position and converts each pixel to Y, U and V in three
// stages: input register, coefficient products, sums.
// ----------------------------------------------------------------------------
module ryc_color import ryc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ryc_pixel_if.sink   req_bus,
   input  ryc_cfg_type cfg,
   input  logic        s3_advance,
   output logic        s3_valid,
   output ryc_yuv_type s3_item,
   output ryc_rd_type  rd_req
);

   // Raster position.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             line_end, frame_end;
   logic             accept;

   // Stage enables.
   logic en1, en2;

   // Stage 1: input pixel.
   logic              s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]  s1_r_ff, s1_g_ff, s1_b_ff;
   logic              s1_odd_col_ff, s1_odd_row_ff;
   logic [SLOT_W-1:0] s1_slot_ff;

   // Stage 2: products.
   logic              s2_valid_ff, s2_valid_in;
   logic [PROD_W-1:0] s2_yr_ff, s2_yg_ff, s2_yb_ff;
   logic [PROD_W-1:0] s2_ur_ff, s2_ug_ff, s2_ub_ff;
   logic [PROD_W-1:0] s2_vr_ff, s2_vg_ff, s2_vb_ff;
   logic              s2_odd_col_ff, s2_odd_row_ff;
   logic [SLOT_W-1:0] s2_slot_ff;

   // Stage 3: sums.
   logic              s3_valid_ff, s3_valid_in;
   ryc_yuv_type       s3_item_ff, s3_item_in;
   logic [PROD_W-1:0] y_sum, u_sum, v_sum;

   // A stage moves on when the next one is empty or moving too.
   assign en2            = !s3_valid_ff || s3_advance;
   assign en1            = !s2_valid_ff || en2;
   assign req_bus.ready  = !s1_valid_ff || en1;
   assign accept         = req_bus.valid && req_bus.ready;

   // Line and frame wrap.
   assign line_end  = (CMP_W'(col_ff) + CMP_W'(1) >= CMP_W'(cfg.pixels_per_line)) ||
                      (col_ff == COL_LAST);
   assign frame_end = (CFG_W'(row_ff) + CFG_W'(1) >= cfg.lines_per_frame) ||
                      (row_ff == ROW_LAST);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (line_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !en1);
   assign s2_valid_in = (s1_valid_ff && en1) || (s2_valid_ff && !en2);
   assign s3_valid_in = (s2_valid_ff && en2) || (s3_valid_ff && !s3_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage 1 payload: pixel and its position.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_r_ff       <= req_bus.red;
         s1_g_ff       <= req_bus.green;
         s1_b_ff       <= req_bus.blue;
         s1_odd_col_ff <= col_ff[0];
         s1_odd_row_ff <= row_ff[0];
         s1_slot_ff    <= col_ff[COL_W-1:1];
      end
   end

   // Stage 2 payload: the nine coefficient products.
   always_ff @(posedge clock) begin
      if (s1_valid_ff && en1) begin
         s2_yr_ff      <= PROD_W'(s1_r_ff) * PROD_W'(C_Y_R);
         s2_yg_ff      <= PROD_W'(s1_g_ff) * PROD_W'(C_Y_G);
         s2_yb_ff      <= PROD_W'(s1_b_ff) * PROD_W'(C_Y_B);
         s2_ur_ff      <= PROD_W'(s1_r_ff) * PROD_W'(C_U_R);
         s2_ug_ff      <= PROD_W'(s1_g_ff) * PROD_W'(C_U_G);
         s2_ub_ff      <= PROD_W'(s1_b_ff) * PROD_W'(C_U_B);
         s2_vr_ff      <= PROD_W'(s1_r_ff) * PROD_W'(C_V_R);
         s2_vg_ff      <= PROD_W'(s1_g_ff) * PROD_W'(C_V_G);
         s2_vb_ff      <= PROD_W'(s1_b_ff) * PROD_W'(C_V_B);
         s2_odd_col_ff <= s1_odd_col_ff;
         s2_odd_row_ff <= s1_odd_row_ff;
         s2_slot_ff    <= s1_slot_ff;
      end
   end

   // Stage 3: the sums are positive and below 2^24, so bits 23..16 are the
   // truncated result.
   assign y_sum = s2_yr_ff + s2_yg_ff + s2_yb_ff + Y_OFFSET;
   assign u_sum = UV_OFFSET + s2_ub_ff - s2_ur_ff - s2_ug_ff;
   assign v_sum = UV_OFFSET + s2_vr_ff - s2_vg_ff - s2_vb_ff;

   always_comb begin
      s3_item_in.luma    = y_sum[PROD_W-1:PROD_W-PIX_W];
      s3_item_in.u       = u_sum[PROD_W-1:PROD_W-PIX_W];
      s3_item_in.v       = v_sum[PROD_W-1:PROD_W-PIX_W];
      s3_item_in.odd_col = s2_odd_col_ff;
      s3_item_in.odd_row = s2_odd_row_ff;
      s3_item_in.slot    = s2_slot_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && en2) begin
         s3_item_ff <= s3_item_in;
      end
   end

   // The odd-row, odd-column pixel fetches its pair sum as it enters stage 3.
   assign rd_req.en   = s2_valid_ff && en2 && s2_odd_col_ff && s2_odd_row_ff;
   assign rd_req.slot = s2_slot_ff;

   assign s3_valid = s3_valid_ff;
   assign s3_item  = s3_item_ff;

endmodule

// ----- hdl/ryc_chroma.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter chroma subsampler
// Holds the left pixel's chroma, keeps even-row pair sums in the line store,
// forms the 2x2 block averages and drives the result register.
// ----------------------------------------------------------------------------
module ryc_chroma import ryc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        s3_valid,
   input  ryc_yuv_type s3_item,
   input  ryc_rd_type  rd_req,
   output logic        s3_advance,
   ryc_result_if.source rsp_bus
);

   // Line store of U and V pair sums, V in the upper half.
   logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   logic [PIX_W-1:0]   left_u_ff, left_u_in;
   logic [PIX_W-1:0]   left_v_ff, left_v_in;

   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   luma_ff;
   logic               chroma_valid_ff, chroma_valid_in;
   logic [PIX_W-1:0]   chroma_u_ff, chroma_u_in;
   logic [PIX_W-1:0]   chroma_v_ff, chroma_v_in;

   logic               fire;
   logic               wr_en;
   logic [PAIR_W-1:0]  pair_u, pair_v;
   logic [BLOCK_W-1:0] block_u, block_v;

   assign s3_advance = !out_valid_ff || rsp_bus.ready;
   assign fire       = s3_valid && s3_advance;

   // Pair sums of the left and current pixel, and the full block sums.
   assign pair_u  = PAIR_W'(left_u_ff) + PAIR_W'(s3_item.u);
   assign pair_v  = PAIR_W'(left_v_ff) + PAIR_W'(s3_item.v);
   assign block_u = BLOCK_W'(rdata_ff[PAIR_W-1:0]) + BLOCK_W'(left_u_ff) +
                    BLOCK_W'(s3_item.u);
   assign block_v = BLOCK_W'(rdata_ff[ENTRY_W-1:PAIR_W]) + BLOCK_W'(left_v_ff) +
                    BLOCK_W'(s3_item.v);

   assign wr_en = fire && s3_item.odd_col && !s3_item.odd_row;

   // Line store: one write and one registered read per cycle. A reader is at
   // least two pixels behind the writer of its entry, so the write always
   // lands before the read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[s3_item.slot] <= {pair_v, pair_u};
      end
      if (rd_req.en) begin
         rdata_ff <= store_mem[rd_req.slot];
      end
   end

   // Even-column pixels park their chroma for the pixel to their right.
   always_comb begin
      left_u_in = left_u_ff;
      left_v_in = left_v_ff;
      if (fire && !s3_item.odd_col) begin
         left_u_in = s3_item.u;
         left_v_in = s3_item.v;
      end
   end

   // Block average on the odd-row, odd-column pixel, zero elsewhere.
   always_comb begin
      chroma_valid_in = s3_item.odd_col && s3_item.odd_row;
      chroma_u_in     = chroma_valid_in ? block_u[BLOCK_W-1:2] : '0;
      chroma_v_in     = chroma_valid_in ? block_v[BLOCK_W-1:2] : '0;
   end

   assign out_valid_in = s3_valid || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_u_ff    <= '0;
         left_v_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_u_ff    <= left_u_in;
         left_v_ff    <= left_v_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (fire) begin
         luma_ff         <= s3_item.luma;
         chroma_valid_ff <= chroma_valid_in;
         chroma_u_ff     <= chroma_u_in;
         chroma_v_ff     <= chroma_v_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.luma         = luma_ff;
   assign rsp_bus.chroma_valid = chroma_valid_ff;
   assign rsp_bus.chroma_u     = chroma_u_ff;
   assign rsp_bus.chroma_v     = chroma_v_ff;

endmodule

// ----- hdl/rgb_to_yuv420_converter.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter
// Converts a raster stream of RGB pixels to BT.601 Y per pixel and 4:2:0
// subsampled U and V per 2x2 block.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_bus   in         red, green, blue of one pixel, raster order
//  rsp_bus   out        luma, chroma_valid, chroma_u, chroma_v per pixel
//  csr_*     in/out     APB registers: pixels_per_line, lines_per_frame
//
// One pixel per clock is sustained while rsp_bus is ready; a pixel's result
// passes the input, product, sum and result registers before it is offered.
// The line store takes one write and one read per cycle, which sets that rate.
// Reset is synchronous; the line store needs no clearing pass.
// A stalled result holds only the stages behind it; empty stages keep taking
// pixels until the pipeline is full.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter import ryc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ryc_pixel_if.sink             req_bus,
   ryc_result_if.source          rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   ryc_cfg_type cfg;
   logic        s3_valid;
   logic        s3_advance;
   ryc_yuv_type s3_item;
   ryc_rd_type  rd_req;

   // Configuration registers.
   ryc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Position tracking and color matrix.
   ryc_color u_color (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg),
      .s3_advance (s3_advance),
      .s3_valid   (s3_valid),
      .s3_item    (s3_item),
      .rd_req     (rd_req)
   );

   // Line store, block averaging and result register.
   ryc_chroma u_chroma (
      .clock      (clock),
      .reset      (reset),
      .s3_valid   (s3_valid),
      .s3_item    (s3_item),
      .rd_req     (rd_req),
      .s3_advance (s3_advance),
      .rsp_bus    (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("result offered after reset");

   // Luma stays inside the studio range the coefficients produce.
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.luma >= 8'd16 && rsp_bus.luma <= 8'd235))
      else $error("luma outside studio range");

   // Chroma fields are zero unless they carry a block average.
   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.chroma_valid) |->
      (rsp_bus.chroma_u == '0 && rsp_bus.chroma_v == '0))
      else $error("chroma not cleared on pixel without block");

   // A line store read is only issued for a pixel entering the sum stage.
   a_read_on_move: assert property (@(posedge clock) disable iff (reset)
      rd_req.en |=> s3_valid && s3_item.odd_col && s3_item.odd_row)
      else $error("line store read without matching pixel");
`endif

endmodule

// ----- bench/rgb_to_yuv420_converter_tb.sv -----
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter testbench
// Streams RGB pixels into the converter under several line and frame sizes
// and checks every result against a cycle-free predictor of Y, the 2x2 chroma
// averages and the raster position, with random idling on both channels.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ryc_pkg::*;

   // BT.601 coefficients in 16-bit fixed point, with the output offsets.
   localparam int unsigned K_Y_R       = 16843;
   localparam int unsigned K_Y_G       = 33030;
   localparam int unsigned K_Y_B       = 6423;
   localparam int unsigned K_U_R       = 9699;
   localparam int unsigned K_U_G       = 19071;
   localparam int unsigned K_U_B       = 28770;
   localparam int unsigned K_V_R       = 28770;
   localparam int unsigned K_V_G       = 24117;
   localparam int unsigned K_V_B       = 4653;
   localparam int unsigned LUMA_BIAS   = 16 << 16;
   localparam int unsigned CHROMA_BIAS = 128 << 16;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic             chroma_valid;
      logic [PIX_W-1:0] chroma_u;
      logic [PIX_W-1:0] chroma_v;
   } yuv_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ryc_pixel_if  req_if ();
   ryc_result_if rsp_if ();

   rgb_to_yuv420_converter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register values as the converter should hold them.
   logic [CFG_W-1:0]   line_width;
   logic [CFG_W-1:0]   frame_height;

   // Predicted converter state.
   logic [COL_W-1:0]   raster_col;
   logic [ROW_W-1:0]   raster_row;
   logic [PIX_W-1:0]   held_u;
   logic [PIX_W-1:0]   held_v;
   logic [ENTRY_W-1:0] pair_sums [STORE_DEPTH];

   // Raster position of the next pixel to be queued, used to align phases.
   logic [COL_W-1:0]   feed_col = '0;
   logic [ROW_W-1:0]   feed_row = '0;

   rgb_pixel_type  pending_pixels [$];
   yuv_result_type expected_yuv [$];

   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   int   hold_left          = 0;
   logic hold_armed         = 1'b0;
   logic hold_taken         = 1'b0;
   int   cycle_count        = 0;
   int   mismatches         = 0;
   int   pixels_checked     = 0;
   int   blocks_checked     = 0;
   int   settings_applied   = 0;

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Advance a raster position by one pixel under the given sizes.
   task automatic step_raster(inout logic [COL_W-1:0] col, inout logic [ROW_W-1:0] row,
                              input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
      if (int'(col) + 1 >= int'(width) || col == COL_LAST) begin
         col = '0;
         if (int'(row) + 1 >= int'(height) || row == ROW_LAST) begin
            row = '0;
         end else begin
            row = row + 1'b1;
         end
      end else begin
         col = col + 1'b1;
      end
   endtask

   // Convert one accepted pixel, update the chroma state and queue its result.
   task automatic compute_yuv420(input rgb_pixel_type px);
      int unsigned        y_acc;
      int unsigned        u_acc;
      int unsigned        v_acc;
      logic [PAIR_W-1:0]  u_pair;
      logic [PAIR_W-1:0]  v_pair;
      logic [BLOCK_W-1:0] u_block;
      logic [BLOCK_W-1:0] v_block;
      logic [SLOT_W-1:0]  slot;
      yuv_result_type     res;
      y_acc = K_Y_R * px.red + K_Y_G * px.green + K_Y_B * px.blue + LUMA_BIAS;
      u_acc = CHROMA_BIAS + K_U_B * px.blue - K_U_R * px.red - K_U_G * px.green;
      v_acc = CHROMA_BIAS + K_V_R * px.red - K_V_G * px.green - K_V_B * px.blue;
      slot = raster_col[COL_W-1:1];
      res = '0;
      // The integer part sits in bits 23..16 and never exceeds 8 bits.
      res.luma = y_acc[23:16];
      if (!raster_col[0]) begin
         held_u = u_acc[23:16];
         held_v = v_acc[23:16];
      end else if (!raster_row[0]) begin
         u_pair = held_u + u_acc[23:16];
         v_pair = held_v + v_acc[23:16];
         pair_sums[slot] = {v_pair, u_pair};
      end else begin
         u_block = pair_sums[slot][PAIR_W-1:0] + held_u + u_acc[23:16];
         v_block = pair_sums[slot][ENTRY_W-1:PAIR_W] + held_v + v_acc[23:16];
         res.chroma_valid = 1'b1;
         res.chroma_u = u_block[BLOCK_W-1:2];
         res.chroma_v = v_block[BLOCK_W-1:2];
      end
      step_raster(raster_col, raster_row, line_width, frame_height);
      expected_yuv.push_back(res);
   endtask

   task automatic flag_mismatch(input string detail);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("Mismatch: %s", detail);
      end
   endtask

   // Pixel driver: records each transfer and offers the next pending pixel.
   always @(posedge clock) begin : pixel_driver
      rgb_pixel_type next_px;
      if (reset) begin
         req_if.valid <= 1'b0;
         raster_col = '0;
         raster_row = '0;
         held_u = '0;
         held_v = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            compute_yuv420({req_if.red, req_if.green, req_if.blue});
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_px = pending_pixels.pop_front();
               req_if.valid <= 1'b1;
               req_if.red   <= next_px.red;
               req_if.green <= next_px.green;
               req_if.blue  <= next_px.blue;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      yuv_result_type got;
      yuv_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.luma, rsp_if.chroma_valid, rsp_if.chroma_u, rsp_if.chroma_v};
            if (expected_yuv.size() == 0) begin
               flag_mismatch($sformatf("unexpected result Y=%0d chroma=%0b U=%0d V=%0d",
                                       got.luma, got.chroma_valid, got.chroma_u,
                                       got.chroma_v));
            end else begin
               want = expected_yuv.pop_front();
               if (got.luma !== want.luma || got.chroma_valid !== want.chroma_valid ||
                   got.chroma_u !== want.chroma_u || got.chroma_v !== want.chroma_v) begin
                  flag_mismatch($sformatf({"pixel %0d: expected Y=%0d chroma=%0b U=%0d V=%0d,",
                                           " got Y=%0d chroma=%0b U=%0d V=%0d"},
                                          pixels_checked, want.luma, want.chroma_valid,
                                          want.chroma_u, want.chroma_v, got.luma,
                                          got.chroma_valid, got.chroma_u, got.chroma_v));
               end
               pixels_checked++;
               if (want.chroma_valid) begin
                  blocks_checked++;
               end
            end
         end
         rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // One long receiver hold-off, started once when armed.
   always @(posedge clock) begin : receiver_hold_off
      if (hold_armed && !hold_taken) begin
         hold_left  <= HOLD_OFF_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin : run_watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // One APB transfer: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic write, input logic [CSR_IDX_W-1:0] index,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b0, index, '0, readback);
      if (readback !== CSR_DATA_W'(value)) begin
         flag_mismatch($sformatf("register %0d read %0d, expected %0d", index, readback,
                                 value));
      end
   endtask

   // Write a register with noise in the unused upper bits, then read it back.
   task automatic apply_setting(input logic [CSR_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] ignored;
      wdata = $urandom();
      wdata[CFG_W-1:0] = value;
      csr_access(1'b1, index, wdata, ignored);
      if (index == REG_PIXELS_PER_LINE) begin
         line_width = value;
      end else begin
         frame_height = value;
      end
      check_register(index, value);
   endtask

   // Wait until every queued pixel has been sent and every result checked.
   task automatic wait_for_drain();
      do @(posedge clock);
      while (pending_pixels.size() != 0 || req_if.valid || expected_yuv.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic start_phase(input int width, input int height, input int idle_pct,
                              input int stall_pct);
      wait_for_drain();
      apply_setting(REG_PIXELS_PER_LINE, CFG_W'(width));
      apply_setting(REG_LINES_PER_FRAME, CFG_W'(height));
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      settings_applied++;
   endtask

   task automatic queue_rgb(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
      pending_pixels.push_back({r, g, b});
      step_raster(feed_col, feed_row, line_width, frame_height);
   endtask

   // Mostly uniform levels, with black and full scale favored.
   function automatic logic [PIX_W-1:0] pick_level();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // Random pixels; when aligning, pad to the start of an even line so the
   // next setting never reads a line store entry that the even row skipped.
   task automatic queue_random(input int count, input bit align);
      for (int i = 0; i < count; i++) begin
         queue_rgb(pick_level(), pick_level(), pick_level());
      end
      while (align && (feed_col != 0 || feed_row[0])) begin
         queue_rgb(pick_level(), pick_level(), pick_level());
      end
   endtask

   // Test sequence.
   initial begin : test_sequence
      int idle_modes [4][2];
      idle_modes = '{'{0, 0}, '{87, 0}, '{0, 87}, '{19, 19}};
      req_if.valid = 1'b0;
      req_if.red   = '0;
      req_if.green = '0;
      req_if.blue  = '0;
      rsp_if.ready = 1'b0;
      line_width   = PIXELS_PER_LINE_RESET;
      frame_height = LINES_PER_FRAME_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      check_register(REG_PIXELS_PER_LINE, PIXELS_PER_LINE_RESET);
      check_register(REG_LINES_PER_FRAME, LINES_PER_FRAME_RESET);

      // Directed 4x2 frames: white and pure blue blocks, then a red block and a
      // black-over-green block for the chroma extremes.
      start_phase(4, 2, 0, 0);
      repeat (2) begin
         queue_rgb(8'hFF, 8'hFF, 8'hFF);
         queue_rgb(8'hFF, 8'hFF, 8'hFF);
         queue_rgb(8'h00, 8'h00, 8'hFF);
         queue_rgb(8'h00, 8'h00, 8'hFF);
      end
      queue_rgb(8'hFF, 8'h00, 8'h00);
      queue_rgb(8'hFF, 8'h00, 8'h00);
      queue_rgb(8'h00, 8'h00, 8'h00);
      queue_rgb(8'h00, 8'h00, 8'h00);
      queue_rgb(8'hFF, 8'h00, 8'h00);
      queue_rgb(8'hFF, 8'h00, 8'h00);
      queue_rgb(8'h00, 8'hFF, 8'h00);
      queue_rgb(8'h00, 8'hFF, 8'h00);

      // Directed 3x3 frame: odd width and odd height.
      start_phase(3, 3, 0, 0);
      queue_rgb(8'h00, 8'hFF, 8'hFF);
      queue_rgb(8'hFF, 8'h00, 8'hFF);
      queue_rgb(8'hFF, 8'hFF, 8'h00);
      queue_rgb(8'h80, 8'h80, 8'h80);
      queue_rgb(8'h7F, 8'h7F, 8'h7F);
      queue_rgb(8'h01, 8'hFE, 8'h55);
      queue_rgb(8'hAA, 8'h55, 8'hFE);
      queue_rgb(8'hFF, 8'hFF, 8'hFF);
      queue_rgb(8'h00, 8'h00, 8'h00);

      // A wide line: many line store slots are written and read back.
      start_phase(128, 2, 0, 0);
      queue_random(2 * 128, 1'b1);

      // One pixel per line through a tall frame, so the row wraps.
      start_phase(1, 64, 0, 0);
      queue_random(64 + 4, 1'b1);

      start_phase(2, 2, 87, 0);
      queue_random(100, 1'b1);
      start_phase(6, 4, 0, 87);
      queue_random(120, 1'b1);
      start_phase(7, 5, 19, 19);
      queue_random(120, 1'b1);

      // Long receiver hold-off while pixels keep coming: the pipe fills up.
      start_phase(16, 8191, 0, 0);
      hold_armed <= 1'b1;
      queue_random(180, 1'b1);

      // Zero sizes end every line; a height of one keeps every line even.
      start_phase(0, 0, 87, 0);
      queue_random(60, 1'b1);
      start_phase(5, 1, 19, 19);
      queue_random(60, 1'b1);

      for (int p = 0; p < 4; p++) begin
         start_phase($urandom_range(40, 2), $urandom_range(12, 2), idle_modes[p][0],
                     idle_modes[p][1]);
         queue_random(60, 1'b1);
      end

      // An over-range width acts as the widest line; no setting follows.
      start_phase(8191, 2, 19, 19);
      queue_random(120, 1'b0);

      wait_for_drain();
      if (expected_yuv.size() != 0) begin
         flag_mismatch($sformatf("%0d results never arrived", expected_yuv.size()));
      end
      $display("Checked %0d pixels and %0d chroma blocks over %0d size settings,",
               pixels_checked, blocks_checked, settings_applied);
      $display("from 0 to over-range widths and heights, with %0d mismatches.", mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/ryc_pkg.sv
hdl/ryc_ifs.sv
hdl/ryc_csr.sv
hdl/ryc_color.sv
hdl/ryc_chroma.sv
hdl/rgb_to_yuv420_converter.sv
bench/rgb_to_yuv420_converter_tb.sv
